// File: rtl/smpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 32;

  // Payload field on the stream is 32 bits; only this many bits are kept.
  localparam int STORE_W = (PAYLOAD_WIDTH < 32) ? PAYLOAD_WIDTH : 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam int PRIO_W = 16;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_REMOVE = 1'b1
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [STORE_W-1:0]       payload;
  } entry_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/smpq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module smpq_cell (
  input  wire logic                clk,
  input  wire smpq_pkg::cell_ctrl_t ctrl,
  input  wire logic                occ,
  input  wire smpq_pkg::entry_t    prev_entry,
  input  wire logic                prev_ahead,
  input  wire smpq_pkg::entry_t    next_entry,
  output smpq_pkg::entry_t         entry,
  output logic                     ahead
);
  import smpq_pkg::*;

  // The new entry goes ahead of this one only on a strictly smaller priority,
  // so equal priorities stay in arrival order.
  assign ahead = !occ || ($signed(ctrl.new_entry.prio) < $signed(entry.prio));

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (prev_ahead) begin
        entry <= prev_entry;
      end else if (ahead) begin
        entry <= ctrl.new_entry;
      end
    end else if (ctrl.rem) begin
      entry <= next_entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stable_min_priority_queue.sv
// Stable minimum priority queue, held as a sorted chain of cells.
// Input stream: s_tuser selects the request (0 insert, 1 remove minimum);
// s_tdata carries the payload and the signed priority of an insert.
// Output stream: one response per request with the removed payload, a
// status (0 ok, 1 remove on empty, 2 insert on full) and the occupancy
// after the request.
// The chain keeps entries ordered by priority and, within a priority, by
// arrival, so the head cell always holds the entry to remove. An insert
// shifts the tail of the chain one cell back; a remove shifts it forward.
// Every request is done in the cycle it is accepted: the response appears
// on the master side in the next cycle, and a new request is taken every
// cycle as long as the response register is empty or being drained.
// When the receiver stalls, the response register holds and s_tready
// drops until the response is taken.
// Reset empties the queue and drops m_tvalid; stored entries and the
// response fields themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module stable_min_priority_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [31:0] payload, [47:32] prio
  input  wire logic        s_tuser,   // [0] func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // [31:0] out_payload, [33:32] status,
                                      // [38:34] occupancy, [39] zero
);
  import smpq_pkg::*;

  logic [CNT_W-1:0]    count;
  logic [DATA_W-1:0]   out_payload;
  status_t             status;
  logic [OCC_W-1:0]    occupancy;

  entry_t     entries [DEPTH];
  logic       aheads  [DEPTH];
  cell_ctrl_t ctrl;

  logic accept;
  logic is_remove;
  logic full;
  logic empty;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign is_remove = (s_tuser == FUNC_REMOVE);
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);

  assign ctrl.ins                = accept && !is_remove && !full;
  assign ctrl.rem                = accept && is_remove && !empty;
  assign ctrl.new_entry.prio     = s_tdata[47:32];
  assign ctrl.new_entry.payload  = s_tdata[STORE_W-1:0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_e;
    logic   prev_b;
    entry_t next_e;

    if (i == 0) begin : g_head
      assign prev_e = ctrl.new_entry;
      assign prev_b = 1'b0;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_b = aheads[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_e = entries[i];
    end else begin : g_mid
      assign next_e = entries[i+1];
    end

    smpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (count > CNT_W'(i)),
      .prev_entry (prev_e),
      .prev_ahead (prev_b),
      .next_entry (next_e),
      .entry      (entries[i]),
      .ahead      (aheads[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (ctrl.ins) begin
        count <= count + 1'b1;
      end else if (ctrl.rem) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_payload <= '0;
      status      <= ST_OK;
      if (is_remove) begin
        if (empty) begin
          status    <= ST_EMPTY;
          occupancy <= '0;
        end else begin
          out_payload <= DATA_W'(entries[0].payload);
          occupancy   <= OCC_W'(count - 1'b1);
        end
      end else begin
        if (full) begin
          status    <= ST_FULL;
          occupancy <= OCC_W'(count);
        end else begin
          occupancy <= OCC_W'(count + 1'b1);
        end
      end
    end
  end

  assign m_tdata = {1'b0, occupancy, status, out_payload};

endmodule

`default_nettype wire
